>>> hw/rtl/tgcs_pkg.sv
package tgcs_pkg;

  // Grid geometry (power of two side)
  localparam int GRID_SIDE   = 64;
  localparam int CW          = $clog2(GRID_SIDE);        // column / row index bits
  localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int BANK_AW     = 2 * (CW - 1);             // address bits of one parity bank
  localparam int NUM_BANKS   = 4;

  // Field widths
  localparam int STEP_W  = 22;
  localparam int FRAC_W  = 16;
  localparam int COLOR_W = 16;
  localparam int IDX_W   = 12;
  localparam int PIX_W   = 12;
  localparam int PIXV_W  = 8;
  localparam int GRID_W  = PIX_W + STEP_W;               // pixel * step product
  localparam int DIFF_W  = COLOR_W + 1;
  localparam int PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int Q_SHIFT = 12 + FRAC_W;                  // Q4.12 color times Q0.16 weight

  // Constants
  localparam logic [STEP_W-1:0]         STEP_RESET = STEP_W'(4032);
  localparam logic signed [COLOR_W-1:0] ONE_Q12    = COLOR_W'(4096);
  localparam logic [GRID_W-1:0]         GRID_LIMIT = GRID_W'((GRID_SIDE - 1) * (1 << FRAC_W));
  localparam logic [PIXV_W-1:0]         PIXV_MAX   = 8'hFF;
  localparam logic [PIXV_W-1:0]         PIXV_MIN   = 8'h00;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP = 2'd1;

endpackage

>>> hw/rtl/tgcs_bank_ram.sv
module tgcs_bank_ram #(
  parameter int AW = 10,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/triangle_grid_color_sampler.sv
// Triangle grid color sampler.
// Input channel (in_valid / in_stall): each transfer is either a vertex write
// (in_op = write: in_vertex_color goes to in_vertex_index) or a shade request
// (in_op = shade: pixel in_pixel_x, in_pixel_y). Writes give no result; each
// shade gives one out_pixel_value transfer on the output channel
// (out_valid / out_stall). Results leave in request order.
// cfg_we writes x_step (index 0) or y_step (index 1) from cfg_data; write only
// while the block is idle.
// Throughput: one item per cycle unless out_stall or the clearing pass holds
// the input. The vertex store is split into four parity banks (row bit 0,
// column bit 0), so the corners of any cell sit in four different banks and
// all are read in the same cycle. Pipeline registers to out_valid: multiply,
// store read, weight products, accumulate, scale/clamp register.
// Reset: steps return to 4032; the store is then cleared to 1.0 by a pass
// over 1024 = GRID_SIDE*GRID_SIDE/4 bank addresses, during which in_stall is high.
// Stall: each stage moves when the one ahead is empty or moving, so bubbles
// close up; when out_stall holds a result, input transfers continue until
// the pipeline is full.
module triangle_grid_color_sampler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgcs_pkg::STEP_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [tgcs_pkg::IDX_W-1:0]           in_vertex_index,
  input  logic signed [tgcs_pkg::COLOR_W-1:0]  in_vertex_color,
  input  logic [tgcs_pkg::PIX_W-1:0]           in_pixel_x,
  input  logic [tgcs_pkg::PIX_W-1:0]           in_pixel_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tgcs_pkg::PIXV_W-1:0]          out_pixel_value
);

  localparam int CW      = tgcs_pkg::CW;
  localparam int BANK_AW = tgcs_pkg::BANK_AW;
  localparam int NB      = tgcs_pkg::NUM_BANKS;
  localparam int FRAC_W  = tgcs_pkg::FRAC_W;
  localparam int COLOR_W = tgcs_pkg::COLOR_W;
  localparam int GRID_W  = tgcs_pkg::GRID_W;
  localparam int DIFF_W  = tgcs_pkg::DIFF_W;
  localparam int PROD_W  = tgcs_pkg::PROD_W;
  localparam int ACC_W   = tgcs_pkg::ACC_W;
  localparam int Q_SHIFT = tgcs_pkg::Q_SHIFT;
  localparam int PIXV_W  = tgcs_pkg::PIXV_W;
  localparam int IDX_W   = tgcs_pkg::IDX_W;

  // ---------------- configuration ----------------
  logic [tgcs_pkg::STEP_W-1:0] x_step_r, y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r <= tgcs_pkg::STEP_RESET;
      y_step_r <= tgcs_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tgcs_pkg::CFG_X_STEP: x_step_r <= cfg_data;
        tgcs_pkg::CFG_Y_STEP: y_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- clearing pass ----------------
  logic               clr_busy_r, clr_busy_nxt;
  logic [BANK_AW-1:0] clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // ---------------- pipeline control ----------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic o_ready, adv4, adv3, adv2, adv1;
  logic in_fire, fire1;
  logic s1_op_r;

  assign o_ready  = !out_valid_r || !out_stall;
  assign adv4     = !v4_r || o_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1 || clr_busy_r;
  assign in_fire  = in_valid && !in_stall;
  assign fire1    = v1_r && adv2;

  always_comb begin
    v1_nxt        = adv1 ? in_fire : v1_r;
    // write items retire when they leave stage 1
    v2_nxt        = adv2 ? (v1_r && (s1_op_r == tgcs_pkg::OP_SHADE)) : v2_r;
    v3_nxt        = adv3 ? v2_r : v3_r;
    v4_nxt        = adv4 ? v3_r : v4_r;
    out_valid_nxt = o_ready ? v4_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- stage 1: grid coordinates ----------------
  logic [IDX_W-1:0]          s1_idx_r;
  logic signed [COLOR_W-1:0] s1_color_r;
  logic [GRID_W-1:0]         s1_gx_r, s1_gy_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op_r    <= in_op;
      s1_idx_r   <= in_vertex_index;
      s1_color_r <= in_vertex_color;
      s1_gx_r    <= GRID_W'(in_pixel_x) * GRID_W'(x_step_r);
      s1_gy_r    <= GRID_W'(in_pixel_y) * GRID_W'(y_step_r);
    end
  end

  // saturate to just under the last row / column
  logic [GRID_W-1:0] gx_sat, gy_sat;
  logic [CW-1:0]     left, up, left1, up1;
  logic [FRAC_W-1:0] fx, fy;
  logic [FRAC_W:0]   fsum;

  always_comb begin
    gx_sat = (s1_gx_r >= tgcs_pkg::GRID_LIMIT) ? tgcs_pkg::GRID_LIMIT - 1'b1 : s1_gx_r;
    gy_sat = (s1_gy_r >= tgcs_pkg::GRID_LIMIT) ? tgcs_pkg::GRID_LIMIT - 1'b1 : s1_gy_r;
    left   = gx_sat[FRAC_W +: CW];
    up     = gy_sat[FRAC_W +: CW];
    left1  = left + 1'b1;
    up1    = up + 1'b1;
    fx     = gx_sat[FRAC_W-1:0];
    fy     = gy_sat[FRAC_W-1:0];
    fsum   = {1'b0, fx} + {1'b0, fy};
  end

  // ---------------- vertex store: four parity banks ----------------
  logic [CW-1:0]      wr_col, wr_row;
  logic               wr_fire;
  logic [NB-1:0]      bank_we;
  logic [BANK_AW-1:0] bank_waddr;
  logic [COLOR_W-1:0] bank_wdata;
  logic               bank_re;
  logic [BANK_AW-1:0] bank_raddr [NB];
  logic [COLOR_W-1:0] bank_rdata [NB];

  assign wr_col  = s1_idx_r[CW-1:0];
  assign wr_row  = s1_idx_r[2*CW-1:CW];
  assign wr_fire = fire1 && (s1_op_r == tgcs_pkg::OP_WRITE)
                   && ({1'b0, s1_idx_r} < (IDX_W+1)'(tgcs_pkg::STORE_DEPTH));
  assign bank_re = fire1 && (s1_op_r == tgcs_pkg::OP_SHADE);

  always_comb begin
    logic [CW-1:0] rcol, rrow;
    bank_waddr = clr_busy_r ? clr_addr_r : {wr_row[CW-1:1], wr_col[CW-1:1]};
    bank_wdata = clr_busy_r ? tgcs_pkg::ONE_Q12 : s1_color_r;
    for (int b = 0; b < NB; b++) begin
      bank_we[b] = clr_busy_r || (wr_fire && ({wr_row[0], wr_col[0]} == 2'(b)));
      // pick the corner whose parity matches this bank
      rcol = (left[0] == b[0]) ? left : left1;
      rrow = (up[0] == b[1]) ? up : up1;
      bank_raddr[b] = {rrow[CW-1:1], rcol[CW-1:1]};
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    tgcs_bank_ram #(
      .AW(BANK_AW),
      .DW(COLOR_W)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we[g]),
      .waddr(bank_waddr),
      .wdata(bank_wdata),
      .re   (bank_re),
      .raddr(bank_raddr[g]),
      .rdata(bank_rdata[g])
    );
  end

  // ---------------- stage 2: corner data ----------------
  logic              s2_l0_r, s2_u0_r, s2_lower_r;
  logic [FRAC_W-1:0] s2_fx_r, s2_fy_r;

  always_ff @(posedge clk) begin
    if (bank_re) begin
      s2_l0_r    <= left[0];
      s2_u0_r    <= up[0];
      s2_lower_r <= !fsum[FRAC_W];
      s2_fx_r    <= fx;
      s2_fy_r    <= fy;
    end
  end

  logic signed [COLOR_W-1:0] c_lu, c_ru, c_ld, c_rd, base, ca, cb;
  logic [FRAC_W-1:0]         wa, wb;
  logic signed [DIFF_W-1:0]  da, db;
  logic signed [PROD_W-1:0]  pa, pb;

  always_comb begin
    c_lu = bank_rdata[{s2_u0_r, s2_l0_r}];
    c_ru = bank_rdata[{s2_u0_r, !s2_l0_r}];
    c_ld = bank_rdata[{!s2_u0_r, s2_l0_r}];
    c_rd = bank_rdata[{!s2_u0_r, !s2_l0_r}];
    if (s2_lower_r) begin
      base = c_lu;
      ca   = c_ru;
      wa   = s2_fx_r;
      cb   = c_ld;
      wb   = s2_fy_r;
    end else begin
      // upper triangle: fx, fy are both nonzero, so 1 - f fits 16 bits
      base = c_rd;
      ca   = c_ld;
      wa   = FRAC_W'((FRAC_W+1)'(1 << FRAC_W) - {1'b0, s2_fx_r});
      cb   = c_ru;
      wb   = FRAC_W'((FRAC_W+1)'(1 << FRAC_W) - {1'b0, s2_fy_r});
    end
    da = DIFF_W'(ca) - DIFF_W'(base);
    db = DIFF_W'(cb) - DIFF_W'(base);
    pa = PROD_W'(da) * $signed(PROD_W'({1'b0, wa}));
    pb = PROD_W'(db) * $signed(PROD_W'({1'b0, wb}));
  end

  // ---------------- stage 3: weight products ----------------
  logic signed [COLOR_W-1:0] s3_base_r;
  logic signed [PROD_W-1:0]  s3_pa_r, s3_pb_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_base_r <= base;
      s3_pa_r   <= pa;
      s3_pb_r   <= pb;
    end
  end

  // ---------------- stage 4: accumulate (Q.28) ----------------
  logic signed [ACC_W-1:0] s4_acc_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_acc_r <= (ACC_W'(s3_base_r) <<< FRAC_W) + ACC_W'(s3_pa_r) + ACC_W'(s3_pb_r);
    end
  end

  // ---------------- output: times 255, truncate, clamp ----------------
  logic [ACC_W-1:0]  frac_ext, scaled;
  logic [PIXV_W-1:0] pix_val;
  logic [PIXV_W-1:0] out_val_r;

  always_comb begin
    frac_ext = ACC_W'(s4_acc_r[Q_SHIFT-1:0]);
    scaled   = (frac_ext << PIXV_W) - frac_ext;
    if (s4_acc_r <= 0) begin
      pix_val = tgcs_pkg::PIXV_MIN;
    end else if (|s4_acc_r[ACC_W-1:Q_SHIFT]) begin
      pix_val = tgcs_pkg::PIXV_MAX;     // color at or above 1.0
    end else begin
      pix_val = scaled[Q_SHIFT +: PIXV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      out_val_r <= pix_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_val_r;

endmodule

>>> hw/rtl/tgcs_checker.sv
module tgcs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_op,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tgcs_pkg::PIXV_W-1:0]   out_pixel_value
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_value))
    else $error("stalled result changed or dropped");

  // store clear blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input open or result shown right after reset");

  // clearing pass still running after reset release
  a_clear_runs: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> in_stall)
    else $error("store clear ended too early");

  // a fresh result comes from an earlier shade transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_op == tgcs_pkg::OP_SHADE), 5))
    else $error("result without matching shade transfer");

endmodule

bind triangle_grid_color_sampler tgcs_checker u_tgcs_checker (.*);
